// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top unit. They sample on clk and hold off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ULAR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ULAR_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ULAR_ASSERT_IMPLY(label, ante, cons)

`define ULAR_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== rtl/ular_pkg.sv =====
`default_nettype none

package ular_pkg;

    // Line ring geometry
    localparam int LINE_LEN    = 64;
    localparam int LINE_SLOTS  = 8;
    localparam int SLOT_W      = $clog2(LINE_SLOTS);
    localparam int FILL_W      = $clog2(LINE_LEN + 1);
    localparam int STORE_DEPTH = LINE_SLOTS * LINE_LEN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = 7;

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Stale poll counter
    localparam int              STALE_W     = 3;
    localparam logic [STALE_W-1:0] STALE_MAX   = 3'd7;
    localparam logic [STALE_W-1:0] STALE_LIMIT = 3'd3;

    // Framing characters
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Operation codes on the input port
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic {
        CMD_PUT,
        CMD_GET
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } back_state_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]       line_byte;
        logic             last;
        logic             no_line;
        logic [LEN_W-1:0] line_length;
    } result_t;

    typedef struct packed {
        logic       valid;
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } res_push_t;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [SLOT_W-1:0] slot,
        input logic [FILL_W-1:0] idx
    );
        return ADDR_W'(slot) * ADDR_W'(LINE_LEN) + ADDR_W'(idx);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        return (slot == SLOT_W'(LINE_SLOTS - 1)) ? '0 : slot + SLOT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uart_line_assembler_ring_unit.sv =====
//  Channel  | Handshake            | Transaction when              | Payload
//  ---------+----------------------+-------------------------------+--------------------
//  item     | push / full          | push high, full low           | op, rx_byte
//  result   | pop / empty          | pop high, empty low           | line_byte, last,
//           |                      |                               | no_line, line_length
//
//  A put or a no_line get is taken while the back end is idle and leaves it idle; a get
//  finding a closed line looks up its slot, then reads its bytes on the store's read port.
//  The two-entry front queue keeps taking transactions while a line streams out, until full.
//  Reset clears slot fills, ring pointers and queues at once; the line store is not cleared.
//  A full result queue stalls streaming and any get that answers no_line, and with them
//  every transaction queued behind; puts never wait on the result side by themselves.
`default_nettype none

`include "assert_macros.svh"

module uart_line_assembler_ring_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ular_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output ular_pkg::result_t result
);
    import ular_pkg::*;

    cmd_t                 cmd;
    logic                 cmd_pop;
    res_push_t            res_push;
    logic [OUT_CNT_W-1:0] level;

    // Front end: accept and classify items, hold them until the back end is free
    ular_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .cmd_pop (cmd_pop),
        .cmd     (cmd)
    );

    // Back end: maintain the line ring and stream closed lines
    ular_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .level    (level),
        .res_push (res_push)
    );

    // Result queue: decouple streaming from the consumer
    ular_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .level    (level),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // Drop a result only if the credit check in the back end is broken
    `ULAR_ASSERT_IMPLY(a_outq_no_overflow, res_push.valid, level < OUT_CNT_W'(OUT_DEPTH))
    // Advance the command queue only when it holds an entry
    `ULAR_ASSERT_IMPLY(a_cmd_pop_valid, cmd_pop, cmd.valid)
    // Hold no_line results to their fixed shape
    `ULAR_ASSERT_IMPLY(a_no_line_shape, res_push.valid && res_push.res.no_line,
        res_push.res.last && (res_push.res.line_byte == 8'h00)
        && (res_push.res.line_length == '0))
    // Keep line lengths of streamed bytes within one slot
    `ULAR_ASSERT_NEVER(a_line_len_range, res_push.valid && !res_push.res.no_line
        && ((res_push.res.line_length == '0)
        || (res_push.res.line_length > LEN_W'(LINE_LEN))))

endmodule

`default_nettype wire

// ===== rtl/ular_front.sv =====
`default_nettype none

module ular_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  ular_pkg::item_t item,
    input  logic            cmd_pop,
    output ular_pkg::cmd_t  cmd
);
    import ular_pkg::*;

    cmd_kind_t            kind_mem [CMD_DEPTH];
    logic [7:0]           data_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    cmd_kind_t            kind_in;
    logic                 wr_en;
    logic                 rd_en;

    // Classify the incoming operation
    always_comb
    begin
        unique case (item.op)
            OP_GET:  kind_in = CMD_GET;
            default: kind_in = CMD_PUT;
        endcase
    end

    assign full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign wr_en = push && !full;
    assign rd_en = cmd_pop && (count_reg != '0);

    assign cmd.valid = (count_reg != '0);
    assign cmd.kind  = kind_mem[rd_ptr_reg];
    assign cmd.data  = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_mem[wr_ptr_reg] <= kind_in;
            data_mem[wr_ptr_reg] <= item.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ular_back.sv =====
`default_nettype none

module ular_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ular_pkg::cmd_t                 cmd,
    output logic                           cmd_pop,
    input  logic [ular_pkg::OUT_CNT_W-1:0] level,
    output ular_pkg::res_push_t            res_push
);
    import ular_pkg::*;

    back_state_t        state_reg, state_next;

    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic [FILL_W-1:0]  open_fill_reg, open_fill_next;
    logic [FILL_W-1:0]  fill_reg [LINE_SLOTS];
    logic [FILL_W-1:0]  fill_next [LINE_SLOTS];
    logic [7:0]         prev_reg, prev_next;
    logic [SLOT_W-1:0]  watch_slot_reg, watch_slot_next;
    logic [FILL_W-1:0]  watch_fill_reg, watch_fill_next;
    logic [STALE_W-1:0] stale_reg, stale_next;

    logic [SLOT_W-1:0]  str_slot_reg, str_slot_next;
    logic [FILL_W-1:0]  str_len_reg, str_len_next;
    logic [FILL_W-1:0]  str_idx_reg, str_idx_next;

    logic               stage_valid_reg, stage_valid_next;
    logic               stage_mem_reg, stage_mem_next;
    logic               stage_last_reg, stage_last_next;
    logic [FILL_W-1:0]  stage_len_reg, stage_len_next;

    logic [7:0]         store_mem [STORE_DEPTH];
    logic [7:0]         mem_q_reg;
    logic               store_we;
    logic [ADDR_W-1:0]  store_waddr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    logic               room;
    logic               rd_is_open;
    logic [FILL_W-1:0]  get_len;
    logic               get_none;
    logic               take;
    logic               take_put;
    logic               take_get;
    logic               last_issue;
    logic               close;
    logic [FILL_W-1:0]  close_fill;
    logic               watch_hit;
    logic [STALE_W-1:0] stale_sat;

    assign room       = (level + OUT_CNT_W'(stage_valid_reg)) < OUT_CNT_W'(OUT_DEPTH);
    assign rd_is_open = (read_slot_reg == write_slot_reg);
    assign get_len    = fill_reg[read_slot_reg];
    assign get_none   = rd_is_open || (get_len == '0);
    assign take       = (state_reg == BK_IDLE) && cmd.valid
                        && ((cmd.kind == CMD_PUT) || !get_none || room);
    assign take_put   = take && (cmd.kind == CMD_PUT);
    assign take_get   = take && (cmd.kind == CMD_GET);
    assign last_issue = (str_idx_reg + FILL_W'(1)) == str_len_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (take_get && !get_none)
                    state_next = BK_STREAM;
            end
            BK_STREAM:
            begin
                if (room && last_issue)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_pop                  = take;
        res_push.valid           = stage_valid_reg;
        res_push.res.line_byte   = stage_mem_reg ? mem_q_reg : 8'h00;
        res_push.res.last        = stage_last_reg;
        res_push.res.no_line     = !stage_mem_reg;
        res_push.res.line_length = LEN_W'(stage_len_reg);
    end

    // Line bookkeeping
    always_comb
    begin
        write_slot_next  = write_slot_reg;
        read_slot_next   = read_slot_reg;
        open_fill_next   = open_fill_reg;
        fill_next        = fill_reg;
        prev_next        = prev_reg;
        watch_slot_next  = watch_slot_reg;
        watch_fill_next  = watch_fill_reg;
        stale_next       = stale_reg;
        str_slot_next    = str_slot_reg;
        str_len_next     = str_len_reg;
        str_idx_next     = str_idx_reg;
        stage_valid_next = 1'b0;
        stage_mem_next   = stage_mem_reg;
        stage_last_next  = stage_last_reg;
        stage_len_next   = stage_len_reg;
        store_we         = 1'b0;
        store_waddr      = store_addr(write_slot_reg, open_fill_reg);
        rd_en            = 1'b0;
        rd_addr          = store_addr(str_slot_reg, str_idx_reg);
        close            = 1'b0;
        close_fill       = open_fill_reg;
        watch_hit        = (watch_slot_reg == read_slot_reg) && (open_fill_reg != '0)
                           && (watch_fill_reg == open_fill_reg);
        stale_sat        = (stale_reg == STALE_MAX) ? stale_reg : stale_reg + 1'b1;

        if (take_put)
        begin
            prev_next = cmd.data;
            // A full line closes and drops the byte
            if (open_fill_reg == FILL_W'(LINE_LEN))
            begin
                close = 1'b1;
            end
            else
            begin
                store_we       = 1'b1;
                open_fill_next = open_fill_reg + 1'b1;
                close_fill     = open_fill_reg + 1'b1;
                if (((open_fill_reg == '0) && (cmd.data == CH_GT))
                    || ((prev_reg == CH_CR) && (cmd.data == CH_LF)))
                    close = 1'b1;
            end
        end

        if (take_get)
        begin
            if (rd_is_open)
            begin
                if (watch_hit)
                begin
                    stale_next = stale_sat;
                    if (stale_sat > STALE_LIMIT)
                        close = 1'b1;
                end
                else
                begin
                    watch_slot_next = read_slot_reg;
                    watch_fill_next = open_fill_reg;
                    stale_next      = '0;
                end
                stage_valid_next = 1'b1;
                stage_mem_next   = 1'b0;
                stage_last_next  = 1'b1;
                stage_len_next   = '0;
            end
            else
            begin
                fill_next[read_slot_reg] = '0;
                read_slot_next           = slot_inc(read_slot_reg);
                watch_slot_next          = '0;
                watch_fill_next          = '0;
                stale_next               = '0;
                if (get_len == '0)
                begin
                    stage_valid_next = 1'b1;
                    stage_mem_next   = 1'b0;
                    stage_last_next  = 1'b1;
                    stage_len_next   = '0;
                end
                else
                begin
                    str_slot_next = read_slot_reg;
                    str_len_next  = get_len;
                    str_idx_next  = '0;
                end
            end
        end

        // Stream one byte per cycle while the result queue has space
        if ((state_reg == BK_STREAM) && room)
        begin
            rd_en            = 1'b1;
            stage_valid_next = 1'b1;
            stage_mem_next   = 1'b1;
            stage_last_next  = last_issue;
            stage_len_next   = str_len_reg;
            str_idx_next     = str_idx_reg + 1'b1;
        end

        if (close)
        begin
            fill_next[write_slot_reg] = close_fill;
            write_slot_next           = slot_inc(write_slot_reg);
            open_fill_next            = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            write_slot_reg  <= '0;
            read_slot_reg   <= '0;
            open_fill_reg   <= '0;
            for (int i = 0; i < LINE_SLOTS; i++)
                fill_reg[i] <= '0;
            prev_reg        <= '0;
            watch_slot_reg  <= '0;
            watch_fill_reg  <= '0;
            stale_reg       <= '0;
            str_slot_reg    <= '0;
            str_len_reg     <= '0;
            str_idx_reg     <= '0;
            stage_valid_reg <= 1'b0;
            stage_mem_reg   <= 1'b0;
            stage_last_reg  <= 1'b0;
            stage_len_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            read_slot_reg   <= read_slot_next;
            open_fill_reg   <= open_fill_next;
            fill_reg        <= fill_next;
            prev_reg        <= prev_next;
            watch_slot_reg  <= watch_slot_next;
            watch_fill_reg  <= watch_fill_next;
            stale_reg       <= stale_next;
            str_slot_reg    <= str_slot_next;
            str_len_reg     <= str_len_next;
            str_idx_reg     <= str_idx_next;
            stage_valid_reg <= stage_valid_next;
            stage_mem_reg   <= stage_mem_next;
            stage_last_reg  <= stage_last_next;
            stage_len_reg   <= stage_len_next;
        end
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= cmd.data;
        if (rd_en)
            mem_q_reg <= store_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/ular_outq.sv =====
`default_nettype none

module ular_outq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ular_pkg::res_push_t            res_push,
    output logic [ular_pkg::OUT_CNT_W-1:0] level,
    output logic                           empty,
    input  logic                           pop,
    output ular_pkg::result_t              result
);
    import ular_pkg::*;

    result_t              res_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;
    logic                 wr_en;
    logic                 rd_en;

    assign empty  = (count_reg == '0);
    assign level  = count_reg;
    assign result = res_mem[rd_ptr_reg];
    assign wr_en  = res_push.valid;
    assign rd_en  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            res_mem[wr_ptr_reg] <= res_push.res;
    end

endmodule

`default_nettype wire
